[design/fpc_pkg.sv]
// Shared types, codes and constants of the frustum plane extract and cull block.
package fpc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PLANE_COUNT = 6;
  localparam int ACC_W       = 68;

  // input mode codes
  localparam logic [2:0] MODE_WR_PROJ = 3'd0;
  localparam logic [2:0] MODE_WR_VIEW = 3'd1;
  localparam logic [2:0] MODE_UPDATE  = 3'd2;
  localparam logic [2:0] MODE_POINT   = 3'd3;
  localparam logic [2:0] MODE_BOX     = 3'd4;

  // result kind codes
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_BOX    = 2'd2;

  localparam logic signed [ACC_W-1:0] CLIP_MAX = ACC_W'(64'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] CLIP_MIN = -ACC_W'(64'sh80000000);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_ISSUE  = 12'b000000000010,
    ST_DRAIN  = 12'b000000000100,
    ST_FINISH = 12'b000000001000,
    ST_CO_A   = 12'b000000010000,
    ST_CO_B   = 12'b000000100000,
    ST_CO_FIX = 12'b000001000000,
    ST_SQRT   = 12'b000010000000,
    ST_ZERO   = 12'b000100000000,
    ST_DIV_GO = 12'b001000000000,
    ST_DIV    = 12'b010000000000,
    ST_OUT    = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_CLIP = 2'd0,
    PH_SQ   = 2'd1,
    PH_TEST = 2'd2
  } phase_t;

  // one issue to the multiply-accumulate unit
  typedef struct packed {
    logic        en;
    logic        first;
    logic [31:0] a;
    logic [32:0] b;
  } mac_req_t;

endpackage

[design/frustum_plane_extract_and_cull_top.sv]
// Top level of the frustum plane extract and cull block: sequencer, stores and units.
//
// One beat is taken at a time; s_tready is high only while the block is idle. Matrix
// element writes (modes 0 and 1) give no result. A point test (mode 3) or box test
// (mode 4) runs 48 plane evaluations through the one shared multiply-accumulate unit.
// A plane update (mode 2) forms 16 clip elements, then per plane runs setup and squares,
// the square-root unit and four passes of the divider, or stores zeros for a degenerate
// plane. The result beat waits on m_tready. After reset the matrix and plane stores
// are zero and every test reports outside.
module frustum_plane_extract_and_cull_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // element_index[3:0], element_value[35:4], pos_x[67:36], pos_y[99:68],
  // pos_z[131:100], half_size[162:132], half_height[193:163], zero pad
  input  logic [199:0] s_tdata,
  // mode[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // inside_res[0], degenerate_planes[6:1], zero pad
  output logic [7:0]   m_tdata,
  // kind[1:0]
  output logic [1:0]   m_tuser
);
  import fpc_pkg::*;

  state_t state;
  phase_t phase;

  logic [31:0] proj  [16];
  logic [31:0] view  [16];
  logic [31:0] plane [24];
  logic [31:0] clip  [16];

  logic [3:0]  e;
  logic [1:0]  t;
  logic [2:0]  p;
  logic [1:0]  i;
  logic [2:0]  corner;
  logic signed [31:0] px, py, pz;
  logic [30:0] hs, hh;
  logic [1:0]  kind_r;
  logic        inside_r;
  logic        any_pos;
  logic [5:0]  degen;
  logic [31:0] tmp;
  logic signed [32:0] co_raw [4];
  logic signed [31:0] co     [4];
  logic [31:0] len;

  mac_req_t                  mreq;
  logic signed [ACC_W-1:0]   acc;
  logic                      sq_start, sq_done;
  logic [31:0]               root;
  logic                      dv_start, dv_done;
  logic [61:0]               dividend, quot;

  // input fields
  logic [3:0]         in_idx;
  logic [31:0]        in_val;
  logic signed [31:0] in_x, in_y, in_z;
  logic [30:0]        in_hs, in_hh;
  logic               s_acc;

  assign in_idx = s_tdata[3:0];
  assign in_val = s_tdata[35:4];
  assign in_x   = s_tdata[67:36];
  assign in_y   = s_tdata[99:68];
  assign in_z   = s_tdata[131:100];
  assign in_hs  = s_tdata[162:132];
  assign in_hh  = s_tdata[193:163];
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // box corner coordinates, exact in 33 bits
  logic signed [32:0] cx, cy, cz;
  assign cx = corner[0] ? {px[31], px} + {2'b00, hs} : {px[31], px} - {2'b00, hs};
  assign cy = corner[1] ? {py[31], py} + {2'b00, hs} : {py[31], py} - {2'b00, hs};
  assign cz = corner[2] ? {pz[31], pz} + {2'b00, hh} : {pz[31], pz} - {2'b00, hh};

  // operand select for the shared MAC
  always_comb begin
    mreq.en    = (state == ST_ISSUE);
    mreq.first = (t == 2'd0);
    mreq.a     = '0;
    mreq.b     = '0;
    case (phase)
      PH_CLIP: begin
        mreq.a = view[{e[3:2], t}];
        mreq.b = {proj[{t, e[1:0]}][31], proj[{t, e[1:0]}]};
      end
      PH_SQ: begin
        mreq.a = co[t];
        mreq.b = {co[t][31], co[t]};
      end
      PH_TEST: begin
        mreq.a = plane[{p, t}];
        case (t)
          2'd0:    mreq.b = cx;
          2'd1:    mreq.b = cy;
          2'd2:    mreq.b = cz;
          default: mreq.b = 33'sd1 << 30;
        endcase
      end
      default: ;
    endcase
  end

  fpc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .acc (acc)
  );

  // clip narrowing: floor to FRAC_BITS fraction bits, saturate
  logic signed [ACC_W-1:0] acc_sh;
  logic [31:0]             clip_val;
  assign acc_sh = acc >>> FRAC_BITS;
  always_comb begin
    if (acc_sh > CLIP_MAX)      clip_val = 32'h7FFFFFFF;
    else if (acc_sh < CLIP_MIN) clip_val = 32'h80000000;
    else                        clip_val = acc_sh[31:0];
  end

  logic acc_pos;
  assign acc_pos = (acc > 0);

  // plane column arithmetic
  logic               add_col;
  logic [31:0]        clip_b;
  logic signed [32:0] raw;
  logic               wide;
  assign add_col = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  assign clip_b  = clip[{i, p[2:1]}];
  assign raw     = add_col ? {tmp[31], tmp} + {clip_b[31], clip_b}
                           : {tmp[31], tmp} - {clip_b[31], clip_b};
  assign wide    = (co_raw[0][32] != co_raw[0][31]) || (co_raw[1][32] != co_raw[1][31]) ||
                   (co_raw[2][32] != co_raw[2][31]) || (co_raw[3][32] != co_raw[3][31]);

  assign sq_start = (state == ST_FINISH) && (phase == PH_SQ);

  fpc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .op    (acc[63:0]),
    .root  (root),
    .done  (sq_done)
  );

  // divider operand: |co| scaled by 2^30 for normals, 2^FRAC_BITS for offset
  logic [31:0] mag;
  assign mag      = co[i][31] ? 32'(-co[i]) : co[i];
  assign dividend = (i == 2'd3) ? (62'(mag) << FRAC_BITS) : (62'(mag) << 30);
  assign dv_start = (state == ST_DIV_GO);

  fpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dividend),
    .divisor  (len),
    .quot     (quot),
    .done     (dv_done)
  );

  // signed saturation of the quotient
  logic [31:0] norm_val;
  always_comb begin
    if (co[i][31]) begin
      norm_val = (quot > 62'h80000000) ? 32'h80000000 : 32'(-quot[31:0]);
    end else begin
      norm_val = (quot > 62'h7FFFFFFF) ? 32'h7FFFFFFF : quot[31:0];
    end
  end

  logic anyp;
  assign anyp = any_pos || acc_pos;

  // clip store, written once per element on update
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && phase == PH_CLIP) clip[e] <= clip_val;
  end

  // sequencer and stores
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_CLIP;
      for (int k = 0; k < 16; k++) begin
        proj[k] <= '0;
        view[k] <= '0;
      end
      for (int k = 0; k < 24; k++) plane[k] <= '0;
      e        <= '0;
      t        <= '0;
      p        <= '0;
      i        <= '0;
      corner   <= '0;
      kind_r   <= KIND_STATUS;
      inside_r <= 1'b0;
      any_pos  <= 1'b0;
      degen    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            case (s_tuser)
              MODE_WR_PROJ: proj[in_idx] <= in_val;
              MODE_WR_VIEW: view[in_idx] <= in_val;
              MODE_UPDATE: begin
                phase  <= PH_CLIP;
                e      <= '0;
                t      <= '0;
                degen  <= '0;
                kind_r <= KIND_STATUS;
                state  <= ST_ISSUE;
              end
              MODE_POINT, MODE_BOX: begin
                px       <= in_x;
                py       <= in_y;
                pz       <= in_z;
                hs       <= (s_tuser == MODE_BOX) ? in_hs : '0;
                hh       <= (s_tuser == MODE_BOX) ? in_hh : '0;
                kind_r   <= (s_tuser == MODE_BOX) ? KIND_BOX : KIND_POINT;
                inside_r <= 1'b1;
                any_pos  <= 1'b0;
                p        <= '0;
                corner   <= '0;
                t        <= '0;
                phase    <= PH_TEST;
                state    <= ST_ISSUE;
              end
              default: ;
            endcase
          end
        end

        // feed terms to the MAC
        ST_ISSUE: begin
          t <= t + 2'd1;
          if ((phase == PH_SQ) ? (t == 2'd2) : (t == 2'd3)) state <= ST_DRAIN;
        end

        ST_DRAIN: state <= ST_FINISH;

        ST_FINISH: begin
          t <= '0;
          case (phase)
            PH_CLIP: begin
              e <= e + 4'd1;
              if (e == 4'd15) begin
                p     <= '0;
                i     <= '0;
                state <= ST_CO_A;
              end else begin
                state <= ST_ISSUE;
              end
            end
            PH_SQ: state <= ST_SQRT;
            default: begin
              corner <= corner + 3'd1;
              state  <= ST_ISSUE;
              if (corner == 3'd7) begin
                inside_r <= inside_r && anyp;
                any_pos  <= 1'b0;
                p        <= p + 3'd1;
                if (p == 3'(PLANE_COUNT - 1)) state <= ST_OUT;
              end else begin
                any_pos <= anyp;
              end
            end
          endcase
        end

        // raw plane coefficients
        ST_CO_A: begin
          tmp   <= clip[{i, 2'd3}];
          state <= ST_CO_B;
        end

        ST_CO_B: begin
          co_raw[i] <= raw;
          i         <= i + 2'd1;
          state     <= (i == 2'd3) ? ST_CO_FIX : ST_CO_A;
        end

        ST_CO_FIX: begin
          for (int k = 0; k < 4; k++) begin
            co[k] <= wide ? 32'(co_raw[k] >>> 1) : co_raw[k][31:0];
          end
          phase <= PH_SQ;
          t     <= '0;
          state <= ST_ISSUE;
        end

        ST_SQRT: begin
          if (sq_done) begin
            len <= root;
            i   <= '0;
            if (root == '0) begin
              degen[p] <= 1'b1;
              state    <= ST_ZERO;
            end else begin
              state <= ST_DIV_GO;
            end
          end
        end

        // degenerate plane: store zeros
        ST_ZERO: begin
          plane[{p, i}] <= '0;
          i             <= i + 2'd1;
          if (i == 2'd3) begin
            p     <= p + 3'd1;
            state <= (p == 3'(PLANE_COUNT - 1)) ? ST_OUT : ST_CO_A;
          end
        end

        ST_DIV_GO: state <= ST_DIV;

        ST_DIV: begin
          if (dv_done) begin
            plane[{p, i}] <= norm_val;
            i             <= i + 2'd1;
            if (i == 2'd3) begin
              p     <= p + 3'd1;
              state <= (p == 3'(PLANE_COUNT - 1)) ? ST_OUT : ST_CO_A;
            end else begin
              state <= ST_DIV_GO;
            end
          end
        end

        // result beat
        ST_OUT: begin
          if (m_tready) state <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tuser  = kind_r;
  assign m_tdata  = (kind_r == KIND_STATUS) ? {1'b0, degen, 1'b0}
                                            : {7'b0, inside_r};

endmodule

[design/fpc_mac.sv]
// Shared multiply-accumulate unit: registered 32x33 product, then wide accumulate.
module fpc_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fpc_pkg::mac_req_t                     req,
  output logic signed [fpc_pkg::ACC_W-1:0]      acc
);
  import fpc_pkg::*;

  logic signed [64:0] prod;
  logic               vld;
  logic               first;

  // product stage
  always_ff @(posedge clk) begin
    prod <= $signed(req.a) * $signed(req.b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= 1'b0;
      first <= 1'b0;
    end else begin
      vld   <= req.en;
      first <= req.first;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (vld) begin
      acc <= first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

endmodule

[design/fpc_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
module fpc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] op,
  output logic [31:0] root,
  output logic        done
);
  import fpc_pkg::*;

  logic [63:0] rem;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        busy;
  logic [4:0]  cnt;

  assign trial = r + bitv;
  assign root  = r[31:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= op;
      r    <= '0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        r   <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

[design/fpc_div.sv]
// Iterative restoring divider, 62-bit dividend by 32-bit divisor, one bit per cycle.
module fpc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] dividend,
  input  logic [31:0] divisor,
  output logic [61:0] quot,
  output logic        done
);
  import fpc_pkg::*;

  logic [61:0] dvd;
  logic [31:0] rem;
  logic [31:0] den;
  logic [32:0] trial;
  logic        ge;
  logic        busy;
  logic [5:0]  cnt;

  assign trial = {rem, dvd[61]};
  assign ge    = trial >= {1'b0, den};
  assign quot  = dvd;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd61);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd61) busy <= 1'b0;
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? 32'(trial - {1'b0, den}) : trial[31:0];
      dvd <= {dvd[60:0], ge};
    end
  end

endmodule

[dv/tb_frustum_plane_extract_and_cull_top.sv]
// Self-checking testbench for the frustum plane extract and cull block.
module tb_frustum_plane_extract_and_cull_top;
  import fpc_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [199:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [7:0]   m_tdata;
  logic [1:0]   m_tuser;

  typedef struct {
    logic [2:0]  mode;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] hs;
    logic [30:0] hh;
  } cmd_t;

  typedef struct {
    logic [1:0] kind;
    logic       in_frustum;
    logic [5:0] degen;
  } verdict_t;

  // shadow copy of the block state
  logic [31:0] proj_m [16];
  logic [31:0] view_m [16];
  logic [31:0] planes [24];

  verdict_t verdict_q[$];
  int       mismatches;
  int       n_sent, n_results, n_inside, n_degen;
  int       hold_cycles;

  frustum_plane_extract_and_cull_top dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint clip_elem(int r, int c);
    logic signed [127:0] sum, a, b;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      a = $signed(view_m[4*r+k]);
      b = $signed(proj_m[4*k+c]);
      sum = sum + a * b;
    end
    sum = sum >>> FRAC_BITS;
    if (sum > 128'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (sum < -128'sh80000000) return -64'sh80000000;
    return longint'(sum);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // trunc(v * 2^sh / len), saturated to 32 bits
  function automatic logic [31:0] scale_div(longint v, int sh, logic [63:0] len);
    logic [63:0] mag, q;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    mag = mag << sh;
    q = mag / len;
    if (v < 0) begin
      if (q > 64'h80000000) q = 64'h80000000;
      return 32'(-q);
    end
    if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
    return q[31:0];
  endfunction

  function automatic logic [5:0] rebuild_planes();
    longint      clip [16];
    longint      co [4];
    logic [63:0] ssq, len;
    logic [5:0]  degen;
    bit          add, wide;
    int          col;
    degen = 0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) clip[4*r+c] = clip_elem(r, c);
    for (int p = 0; p < PLANE_COUNT; p++) begin
      col  = p >> 1;
      add  = (p == 1 || p == 2 || p == 5);
      wide = 0;
      for (int i = 0; i < 4; i++) begin
        co[i] = add ? clip[4*i+3] + clip[4*i+col] : clip[4*i+3] - clip[4*i+col];
        if (co[i] > 64'sh7FFFFFFF || co[i] < -64'sh80000000) wide = 1;
      end
      // halving keeps the plane, only brings it back to 32 bits
      if (wide)
        for (int i = 0; i < 4; i++) co[i] = co[i] >>> 1;
      ssq = 0;
      for (int i = 0; i < 3; i++) ssq = ssq + 64'(co[i] * co[i]);
      len = int_sqrt(ssq);
      if (len == 0) begin
        degen[p] = 1'b1;
        for (int i = 0; i < 4; i++) planes[4*p+i] = 0;
      end else begin
        for (int i = 0; i < 3; i++) planes[4*p+i] = scale_div(co[i], 30, len);
        planes[4*p+3] = scale_div(co[3], FRAC_BITS, len);
      end
    end
    return degen;
  endfunction

  function automatic bit plane_above(int p, logic signed [127:0] px,
                                     logic signed [127:0] py, logic signed [127:0] pz);
    logic signed [127:0] a, b, c, d, acc;
    a = $signed(planes[4*p]);
    b = $signed(planes[4*p+1]);
    c = $signed(planes[4*p+2]);
    d = $signed(planes[4*p+3]);
    acc = a * px + b * py + c * pz + (d <<< 30);
    return acc > 0;
  endfunction

  function automatic bit box_inside(cmd_t t);
    logic signed [127:0] x, y, z, hs, hh, cx, cy, cz;
    bit any_pos;
    x  = $signed(t.x);
    y  = $signed(t.y);
    z  = $signed(t.z);
    hs = t.hs;
    hh = t.hh;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      any_pos = 0;
      for (int k = 0; k < 8; k++) begin
        cx = k[0] ? x + hs : x - hs;
        cy = k[1] ? y + hs : y - hs;
        cz = k[2] ? z + hh : z - hh;
        if (plane_above(p, cx, cy, cz)) any_pos = 1;
      end
      if (!any_pos) return 0;
    end
    return 1;
  endfunction

  function automatic void predict_result(cmd_t t);
    verdict_t v;
    bit in_all;
    v = '{kind: KIND_STATUS, in_frustum: 1'b0, degen: 6'd0};
    case (t.mode)
      MODE_WR_PROJ: proj_m[t.idx] = t.val;
      MODE_WR_VIEW: view_m[t.idx] = t.val;
      MODE_UPDATE: begin
        v.degen = rebuild_planes();
        verdict_q.push_back(v);
      end
      MODE_POINT: begin
        in_all = 1;
        for (int p = 0; p < PLANE_COUNT; p++)
          if (!plane_above(p, $signed(t.x), $signed(t.y), $signed(t.z))) in_all = 0;
        v.kind       = KIND_POINT;
        v.in_frustum = in_all;
        verdict_q.push_back(v);
      end
      MODE_BOX: begin
        v.kind       = KIND_BOX;
        v.in_frustum = box_inside(t);
        verdict_q.push_back(v);
      end
      default: ;
    endcase
  endfunction

  // ---------------- sender ----------------
  task automatic send_cmd(cmd_t t);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= t.mode;
    s_tdata  <= {6'd0, t.hh, t.hs, t.z, t.y, t.x, t.val, t.idx};
    do @(posedge clk); while (!s_tready);
    predict_result(t);
    n_sent++;
    // bursty source: sometimes drop valid for a while
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t t;
    t.mode = 3'($urandom_range(0, 7));
    t.idx  = 4'($urandom_range(0, 15));
    t.val  = $urandom;
    t.x    = $urandom;
    t.y    = $urandom;
    t.z    = $urandom;
    t.hs   = 31'($urandom);
    t.hh   = 31'($urandom);
    return t;
  endfunction

  function automatic cmd_t mk(logic [2:0] mode, logic [3:0] idx, logic [31:0] val);
    cmd_t t;
    t = rand_cmd();
    t.mode = mode;
    t.idx  = idx;
    t.val  = val;
    return t;
  endfunction

  function automatic cmd_t mk_probe(logic [2:0] mode, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z, logic [30:0] hs, logic [30:0] hh);
    cmd_t t;
    t = rand_cmd();
    t.mode = mode;
    t.x = x; t.y = y; t.z = z; t.hs = hs; t.hh = hh;
    return t;
  endfunction

  // small signed Q16.16 value, within plus or minus 4.0
  function automatic logic [31:0] small_q();
    return 32'($signed($urandom_range(0, 524288)) - 262144);
  endfunction

  // ---------------- receiver and checker ----------------
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (($urandom_range(0, 63) < 40) || ($urandom_range(0, 15) == 0)) begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      verdict_t e;
      n_results++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d data %h", m_tuser, m_tdata);
      end else begin
        e = verdict_q.pop_front();
        if (m_tuser !== e.kind || m_tdata[0] !== e.in_frustum || m_tdata[6:1] !== e.degen
            || m_tdata[7] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d inside %0d degen %b, got kind %0d data %b",
                     e.kind, e.in_frustum, e.degen, m_tuser, m_tdata);
        end else if (e.kind != KIND_STATUS && e.in_frustum) begin
          n_inside++;
        end else if (e.kind == KIND_STATUS && e.degen != 0) begin
          n_degen++;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_state();
    send_cmd(mk_probe(MODE_POINT, 0, 0, 0, 0, 0));
    send_cmd(mk_probe(MODE_BOX, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF));
    send_cmd(mk(MODE_UPDATE, 0, 0));  // all-zero matrices: every plane degenerate
  endtask

  task automatic test_unused_modes();
    cmd_t t;
    for (int m = 5; m < 8; m++) begin
      t = rand_cmd();
      t.mode = 3'(m);
      send_cmd(t);
    end
  endtask

  // identity matrices give the unit cube as the frustum
  task automatic test_identity_frustum();
    for (int i = 0; i < 16; i++) begin
      send_cmd(mk(MODE_WR_PROJ, 4'(i), (i % 5 == 0) ? 32'h10000 : 32'h0));
      send_cmd(mk(MODE_WR_VIEW, 4'(i), (i % 5 == 0) ? 32'h10000 : 32'h0));
    end
    send_cmd(mk(MODE_UPDATE, 0, 0));
    send_cmd(mk_probe(MODE_POINT, 0, 0, 0, 0, 0));
    send_cmd(mk_probe(MODE_POINT, 32'h10000, 0, 0, 0, 0));       // on the boundary
    send_cmd(mk_probe(MODE_POINT, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0));
    send_cmd(mk_probe(MODE_BOX, 32'h20000, 0, 0, 31'h18000, 31'h8000));
    send_cmd(mk_probe(MODE_BOX, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      31'h7FFFFFFF, 31'h7FFFFFFF));
    send_cmd(mk_probe(MODE_BOX, 32'h30000, 0, 0, 31'h8000, 31'h0));
  endtask

  // extreme matrix elements and zero normals
  task automatic test_extremes();
    for (int i = 0; i < 16; i++) begin
      send_cmd(mk(MODE_WR_PROJ, 4'(i), i[0] ? 32'h7FFFFFFF : 32'h80000000));
      send_cmd(mk(MODE_WR_VIEW, 4'(i), i[1] ? 32'h7FFFFFFF : 32'h80000000));
    end
    send_cmd(mk(MODE_UPDATE, 0, 0));
    send_cmd(mk_probe(MODE_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0));
    send_cmd(mk_probe(MODE_BOX, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                      31'h7FFFFFFF, 31'h7FFFFFFF));
    // only column 3 of the projection nonzero: all six planes get the same coefficients
    for (int i = 0; i < 16; i++)
      send_cmd(mk(MODE_WR_PROJ, 4'(i), (i % 4 == 3) ? 32'h10000 : 32'h0));
    send_cmd(mk(MODE_UPDATE, 0, 0));
  endtask

  // frames: matrix writes, an update, then a run of probes mixed with random noise beats
  task automatic test_random_frames(int frames);
    cmd_t t;
    for (int f = 0; f < frames; f++) begin
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(0, 3) != 0)
          send_cmd(mk(MODE_WR_PROJ, 4'(i), ($urandom_range(0, 4) == 0) ? 32'h0 : small_q()));
        if ($urandom_range(0, 3) != 0)
          send_cmd(mk(MODE_WR_VIEW, 4'(i),
                      ($urandom_range(0, 9) == 0) ? $urandom : small_q()));
      end
      send_cmd(mk(MODE_UPDATE, 0, 0));
      repeat ($urandom_range(6, 14)) begin
        if ($urandom_range(0, 4) == 0) begin
          t = rand_cmd();   // noise, any mode and full-range fields
        end else begin
          t = mk_probe($urandom_range(0, 1) ? MODE_POINT : MODE_BOX, small_q(), small_q(),
                       small_q(), 31'($urandom_range(0, 131072)),
                       31'($urandom_range(0, 131072)));
        end
        send_cmd(t);
      end
    end
  endtask

  // long receiver stall while the source keeps offering probes
  task automatic test_backpressure();
    hold_cycles = 3000;
    repeat (8) send_cmd(mk_probe(MODE_POINT, small_q(), small_q(), small_q(), 0, 0));
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    mismatches = 0;
    n_sent = 0; n_results = 0; n_inside = 0; n_degen = 0;
    hold_cycles = 0;
    foreach (proj_m[i]) begin
      proj_m[i] = 0;
      view_m[i] = 0;
    end
    foreach (planes[i]) planes[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_unused_modes();
    test_identity_frustum();
    test_extremes();
    test_backpressure();
    test_random_frames(34);

    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);

    $display("sent %0d beats, checked %0d results (%0d inside, %0d degenerate updates)",
             n_sent, n_results, n_inside, n_degen);
    $display("covered reset state, unused modes, saturation, zero normals and back-pressure");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, verdict_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #150_000_000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
